FILE: sv/rxdc_pkg.sv
// ----------------------------------------------------------------------------
// rxdc_pkg
// Shared widths, register codes and stage records of the RX differential
// count unit.
// ----------------------------------------------------------------------------
package rxdc_pkg;

    localparam int MAX_WORD    = 31;
    localparam int DIFF_W      = MAX_WORD;
    localparam int WORD_W      = 5;
    localparam int POS_W       = WORD_W + 1;
    localparam int EXP_W       = 6;
    localparam int COUNT_W     = 63;
    localparam int Q_W         = 33;
    localparam int ACC_W       = Q_W + 2;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 64;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [WORD_W-1:0] WORD_SIZE_RST = 5'd16;
    localparam logic [WORD_W-1:0] ROTATION_RST  = 5'd1;

    typedef enum logic
    {
        REG_WORD_SIZE = 1'b0,
        REG_ROTATION  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        SGN_NONE  = 2'd0,
        SGN_PLUS  = 2'd1,
        SGN_MINUS = 2'd2
    } sign_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] word_size;
        logic [WORD_W-1:0] rotation;
    } cfg_t;

    typedef struct packed
    {
        logic              ok;
        logic              err;
        logic              k_zero;
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] k;
        logic [DIFF_W-1:0] w_hi;
        logic [DIFF_W-1:0] w_lo;
        logic              fix_hi;
        logic              fix_lo;
        logic              x_lsb;
        logic              x_kbit;
    } front_t;

    typedef struct packed
    {
        logic              zero;
        logic              err;
        logic              k_zero;
        logic [EXP_W-1:0]  e0;
        logic [WORD_W-1:0] p1;
        logic [WORD_W-1:0] p2;
        sign_t             s1;
        sign_t             s2;
        logic [WORD_W-1:0] sh;
    } count_t;

endpackage

FILE: sv/rxdc_cfg.sv
// ----------------------------------------------------------------------------
// rxdc_cfg
// APB register file holding word size and rotation.
// ----------------------------------------------------------------------------
module rxdc_cfg
    import rxdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [WORD_W-1:0] word_size_reg;
    logic [WORD_W-1:0] word_size_next;
    logic [WORD_W-1:0] rotation_reg;
    logic [WORD_W-1:0] rotation_next;
    reg_idx_t          idx;
    logic              wr;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        word_size_next = word_size_reg;
        rotation_next  = rotation_reg;
        prdata         = '0;
        if (wr)
        begin
            unique case (idx)
                REG_WORD_SIZE: word_size_next = pwdata[WORD_W-1:0];
                REG_ROTATION:  rotation_next  = pwdata[WORD_W-1:0];
                default:       word_size_next = word_size_reg;
            endcase
        end
        unique case (idx)
            REG_WORD_SIZE: prdata = {{(PDATA_W-WORD_W){1'b0}}, word_size_reg};
            REG_ROTATION:  prdata = {{(PDATA_W-WORD_W){1'b0}}, rotation_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_size_reg <= WORD_SIZE_RST;
            rotation_reg  <= ROTATION_RST;
        end
        else
        begin
            word_size_reg <= word_size_next;
            rotation_reg  <= rotation_next;
        end
    end

    assign cfg.word_size = word_size_reg;
    assign cfg.rotation  = rotation_reg;

endmodule

FILE: sv/rxdc_front.sv
// ----------------------------------------------------------------------------
// rxdc_front
// First stage: mask the differences, check the validity criterion and build
// the bit regions for the two part counts.
// ----------------------------------------------------------------------------
module rxdc_front
    import rxdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DIFF_W-1:0] alpha_diff,
    input  logic [DIFF_W-1:0] beta_diff,
    input  logic [DIFF_W-1:0] sum_diff,
    output logic              out_valid,
    input  logic              out_ready,
    output front_t            out_data
);

    logic   valid_reg;
    front_t data_reg;
    front_t data_next;

    always_comb
    begin
        logic [DIFF_W-1:0] mask;
        logic [DIFF_W-1:0] keep;
        logic [DIFF_W-1:0] r_hi;
        logic [DIFF_W-1:0] r_lo;
        logic [DIFF_W-1:0] c_hi;
        logic [DIFF_W-1:0] c_lo;
        logic [DIFF_W-1:0] kbit;
        logic [DIFF_W-1:0] w;
        logic [DIFF_W-1:0] x;
        logic [DIFF_W-1:0] u;
        logic [DIFF_W-1:0] v;
        logic [DIFF_W-1:0] xh;
        logic [DIFF_W-1:0] xl;
        logic [POS_W-1:0]  n6;
        logic [POS_W-1:0]  k6;
        logic [POS_W-1:0]  i6;
        n6 = {1'b0, cfg.word_size};
        k6 = {1'b0, cfg.rotation};
        for (int i = 0; i < DIFF_W; i++)
        begin
            i6      = POS_W'(i);
            mask[i] = i6 < n6;
            kbit[i] = i6 == k6;
            keep[i] = !((k6 != '0) && ((i6 == '0) || (i6 == k6)));
            r_hi[i] = (k6 <= i6) && (i6 < n6);
            r_lo[i] = i6 < k6;
            c_hi[i] = (k6 <= i6) && ((i6 + 1'b1) < n6);
            c_lo[i] = (i6 + 1'b1) < k6;
        end
        w  = ((alpha_diff ^ sum_diff) | (beta_diff ^ sum_diff)) & mask;
        x  = (alpha_diff ^ beta_diff ^ sum_diff) & mask;
        u  = x ^ ({x[DIFF_W-2:0], 1'b0} & mask);
        v  = {w[DIFF_W-2:0], 1'b0} & mask;
        xh = x & r_hi;
        xl = x & r_lo;
        data_next.ok     = (u & ~v & keep) == '0;
        data_next.err    = cfg.rotation >= cfg.word_size;
        data_next.k_zero = cfg.rotation == '0;
        data_next.n      = cfg.word_size;
        data_next.k      = cfg.rotation;
        data_next.w_hi   = w & c_hi;
        data_next.w_lo   = w & c_lo;
        data_next.fix_hi = (xh == '0) || (xh == r_hi);
        data_next.fix_lo = (xl == '0) || (xl == r_lo);
        data_next.x_lsb  = x[0];
        data_next.x_kbit = |(x & kbit);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/rxdc_count.sv
// ----------------------------------------------------------------------------
// rxdc_count
// Second stage: popcount the carry regions and form the exponents and the
// correction signs of the two parts.
// ----------------------------------------------------------------------------
module rxdc_count
    import rxdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output count_t out_data
);

    logic   valid_reg;
    count_t data_reg;
    count_t data_next;

    function automatic logic [WORD_W-1:0] pop31(input logic [DIFF_W-1:0] vec);
        logic [31:0] pv;
        logic [3:0]  g [4];
        pv = {1'b0, vec};
        for (int j = 0; j < 4; j++)
        begin
            g[j] = '0;
            for (int b = 0; b < 8; b++)
            begin
                g[j] = g[j] + 4'(pv[j*8+b]);
            end
        end
        return {1'b0, g[0]} + {1'b0, g[1]} + {1'b0, g[2]} + {1'b0, g[3]};
    endfunction

    always_comb
    begin
        logic [WORD_W-1:0] dd1;
        logic [WORD_W-1:0] dd2;
        dd1 = pop31(in_data.w_hi);
        dd2 = pop31(in_data.w_lo);
        data_next.zero   = !in_data.ok || in_data.err;
        data_next.err    = in_data.err;
        data_next.k_zero = in_data.k_zero;
        data_next.e0     = {in_data.n, 1'b0} - {1'b0, dd1};
        data_next.p1     = in_data.n - in_data.k - dd1;
        data_next.p2     = in_data.k - dd2;
        data_next.sh     = in_data.n - WORD_W'(2);
        if (!in_data.fix_hi)
        begin
            data_next.s1 = SGN_NONE;
        end
        else
        begin
            data_next.s1 = in_data.x_lsb ? SGN_MINUS : SGN_PLUS;
        end
        if (!in_data.fix_lo)
        begin
            data_next.s2 = SGN_NONE;
        end
        else
        begin
            data_next.s2 = in_data.x_kbit ? SGN_MINUS : SGN_PLUS;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/rxdc_combine.sv
// ----------------------------------------------------------------------------
// rxdc_combine
// Third and fourth stages: expand the product of the two parts into a sum of
// powers of two, then scale it (or use 2^e0 or zero) and hold the result word.
// ----------------------------------------------------------------------------
module rxdc_combine
    import rxdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  count_t             in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COUNT_W-1:0] pair_count,
    output logic               config_error
);

    logic               s3_valid_reg;
    logic               s3_zero_reg;
    logic               s3_err_reg;
    logic               s3_k_zero_reg;
    logic [EXP_W-1:0]   s3_e0_reg;
    logic [WORD_W-1:0]  s3_sh_reg;
    logic [Q_W-1:0]     s3_q_reg;
    logic [Q_W-1:0]     s3_q_next;
    logic               s3_ready;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               err_reg;

    function automatic logic [ACC_W-1:0] add_term(input logic [ACC_W-1:0] acc,
                                                  input sign_t            sgn,
                                                  input logic [ACC_W-1:0] term);
        logic [ACC_W-1:0] res;
        unique case (sgn)
            SGN_PLUS:  res = acc + term;
            SGN_MINUS: res = acc - term;
            default:   res = acc;
        endcase
        return res;
    endfunction

    always_comb
    begin
        logic [EXP_W-1:0] psum;
        logic [ACC_W-1:0] acc;
        sign_t            s12;
        psum = EXP_W'(in_data.p1) + EXP_W'(in_data.p2);
        acc  = ACC_W'(1) << psum;
        acc  = add_term(acc, in_data.s2, ACC_W'(1) << in_data.p1);
        acc  = add_term(acc, in_data.s1, ACC_W'(1) << in_data.p2);
        if (in_data.s1 == SGN_NONE || in_data.s2 == SGN_NONE)
        begin
            s12 = SGN_NONE;
        end
        else if (in_data.s1 == in_data.s2)
        begin
            s12 = SGN_PLUS;
        end
        else
        begin
            s12 = SGN_MINUS;
        end
        acc       = add_term(acc, s12, ACC_W'(1));
        s3_q_next = acc[Q_W-1:0];
    end

    always_comb
    begin
        priority if (s3_zero_reg)
        begin
            count_next = '0;
        end
        else if (s3_k_zero_reg)
        begin
            count_next = COUNT_W'(1) << s3_e0_reg;
        end
        else
        begin
            count_next = COUNT_W'(s3_q_reg) << s3_sh_reg;
        end
    end

    assign s3_ready = !out_valid_reg || out_ready;
    assign in_ready = !s3_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s3_zero_reg   <= in_data.zero;
            s3_err_reg    <= in_data.err;
            s3_k_zero_reg <= in_data.k_zero;
            s3_e0_reg     <= in_data.e0;
            s3_sh_reg     <= in_data.sh;
            s3_q_reg      <= s3_q_next;
        end
        if (s3_ready && s3_valid_reg)
        begin
            count_reg <= count_next;
            err_reg   <= s3_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pair_count   = count_reg;
    assign config_error = err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> count_reg == '0)
        else $error("config error with nonzero count");

    a_q_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_zero_reg && !s3_k_zero_reg |-> s3_q_reg != '0)
        else $error("part product collapsed to zero");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && count_reg[COUNT_W-1] |-> count_reg[COUNT_W-2:0] == '0)
        else $error("count above the largest power of two");
`endif

endmodule

FILE: sv/rx_differential_count_unit.sv
// ----------------------------------------------------------------------------
// rx_differential_count_unit
// Four stages: front, count, s3 and output registers, in that order.
// Throughput: one word per cycle, set by this pipeline, while not stalled.
// Each stage holds its word while the next one stalls; bubbles collapse.
// Reset (rst_n low, asynchronous) clears all valid bits and sets
// word_size to 16 and rotation to 1.
// ----------------------------------------------------------------------------
module rx_differential_count_unit
    import rxdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // alpha_diff[30:0], beta_diff[61:31], sum_diff[92:62], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pair_count[62:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // config_error[0]
    output logic                   m_tuser
);

    cfg_t               cfg;
    front_t             front_data;
    logic               front_valid;
    logic               front_ready;
    count_t             count_data;
    logic               count_valid;
    logic               count_ready;
    logic [COUNT_W-1:0] pair_count;

    rxdc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rxdc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .alpha_diff (s_tdata[DIFF_W-1:0]),
        .beta_diff  (s_tdata[2*DIFF_W-1:DIFF_W]),
        .sum_diff   (s_tdata[3*DIFF_W-1:2*DIFF_W]),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    rxdc_count u_count
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (count_valid),
        .out_ready (count_ready),
        .out_data  (count_data)
    );

    rxdc_combine u_combine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (count_valid),
        .in_ready     (count_ready),
        .in_data      (count_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pair_count   (pair_count),
        .config_error (m_tuser)
    );

    assign m_tdata = {{(OUT_TDATA_W-COUNT_W){1'b0}}, pair_count};

endmodule

FILE: tb/tb_rx_differential_count_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rx_differential_count_unit
// Streams difference triples through the counter under several word size and
// rotation settings, predicts each pair count and error flag in a scoreboard,
// and checks each result word in order; mostly both sides stall at random.
// ----------------------------------------------------------------------------
module tb_rx_differential_count_unit;
    import rxdc_pkg::*;

    typedef struct
    {
        logic [COUNT_W-1:0] count;
        logic               err;
    } pair_result_t;

    class count_scoreboard;
        logic [WORD_W-1:0] word_size;
        logic [WORD_W-1:0] rotation;
        pair_result_t      expected_counts[$];
        int unsigned       mismatches;

        function new();
            word_size   = WORD_SIZE_RST;
            rotation    = ROTATION_RST;
            mismatches  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [WORD_W-1:0] value);
            if (idx == REG_WORD_SIZE)
                word_size = value;
            else
                rotation = value;
        endfunction

        function int unsigned outstanding();
            return expected_counts.size();
        endfunction

        function logic [63:0] part_pairs(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                         int unsigned m, bit flip);
            logic [63:0] mask;
            logic [63:0] x;
            logic [63:0] base;
            logic [63:0] corr;
            int unsigned dd;
            mask = (64'd1 << m) - 64'd1;
            dd   = $countones((((a ^ d) | (b ^ d)) << 1) & mask);
            x    = (a ^ b ^ d) & mask;
            base = 64'd1 << (2 * m - dd - 1);
            corr = 64'd1 << (m - 1);
            if (x == 64'd0 || x == mask)
                return flip ? base - corr : base + corr;
            return base;
        endfunction

        function pair_result_t predict(logic [DIFF_W-1:0] a_in, logic [DIFF_W-1:0] b_in,
                                       logic [DIFF_W-1:0] d_in);
            pair_result_t r;
            int unsigned  n;
            int unsigned  k;
            logic [63:0]  mask;
            logic [63:0]  a;
            logic [63:0]  b;
            logic [63:0]  d;
            logic [63:0]  x;
            logic [63:0]  u;
            logic [63:0]  v;
            logic [63:0]  keep;
            logic [63:0]  count;
            n = (word_size > MAX_WORD) ? MAX_WORD : word_size;
            k = rotation;
            if (k >= n)
            begin
                r.count = '0;
                r.err   = 1'b1;
                return r;
            end
            mask = (64'd1 << n) - 64'd1;
            a    = {33'd0, a_in} & mask;
            b    = {33'd0, b_in} & mask;
            d    = {33'd0, d_in} & mask;
            x    = (a ^ b ^ d) & mask;
            u    = x ^ ((x << 1) & mask);
            v    = (((a ^ d) | (b ^ d)) << 1) & mask;
            if (k != 0)
            begin
                keep = mask & ~64'd1 & ~(64'd1 << k);
                u    = u & keep;
                v    = v & keep;
            end
            if ((u & v) != u)
                count = 64'd0;
            else if (k == 0)
                count = 64'd1 << (2 * n - $countones(v));
            else
                count = part_pairs(a >> k, b >> k, d >> k, n - k, x[0])
                      * part_pairs(a, b, d, k, x[k]);
            r.count = count[COUNT_W-1:0];
            r.err   = 1'b0;
            return r;
        endfunction

        function void note_input(logic [DIFF_W-1:0] a, logic [DIFF_W-1:0] b,
                                 logic [DIFF_W-1:0] d);
            expected_counts.push_back(predict(a, b, d));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            pair_result_t want;
            if (expected_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected word: count=%0d err=%0b",
                             $time, tdata[COUNT_W-1:0], tuser);
                return;
            end
            want = expected_counts.pop_front();
            if (tdata[COUNT_W-1:0] !== want.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] pair_count: expected %0d, got %0d",
                             $time, want.count, tdata[COUNT_W-1:0]);
            end
            if (tuser !== want.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] config_error: expected %0b, got %0b",
                             $time, want.err, tuser);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    // alpha_diff[30:0], beta_diff[61:31], sum_diff[92:62], zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // pair_count[62:0], zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;
    // config_error[0]
    logic                   m_tuser;

    count_scoreboard sb;
    bit              tx_idle_en;
    bit              rx_idle_en;
    int unsigned     rx_hold;

    rx_differential_count_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DIFF_W-1:0] rnd_diff();
        logic [31:0] r;
        r = $urandom;
        return r[DIFF_W-1:0];
    endfunction

    // Mix of raw noise, constant-xor parts, sparse words and triples that
    // satisfy the validity criterion bit by bit.
    function automatic void make_triple(int unsigned n, int unsigned k,
                                        output logic [DIFF_W-1:0] a,
                                        output logic [DIFF_W-1:0] b,
                                        output logic [DIFF_W-1:0] d);
        int unsigned       mode;
        logic [DIFF_W-1:0] x;
        bit                hi_fill;
        bit                lo_fill;
        bit                eq_prev;
        bit                x_prev;
        mode = $urandom_range(0, 99);
        a    = rnd_diff();
        b    = rnd_diff();
        d    = rnd_diff();
        if (mode < 20)
            return;
        if (mode < 40)
        begin
            hi_fill = 1'($urandom_range(0, 1));
            lo_fill = 1'($urandom_range(0, 1));
            x       = rnd_diff();
            for (int i = 0; i < n; i++)
                x[i] = (i < k) ? lo_fill : hi_fill;
            b = a ^ (rnd_diff() & rnd_diff() & rnd_diff());
            d = a ^ b ^ x;
            return;
        end
        if (mode < 50)
        begin
            a = a & rnd_diff() & rnd_diff();
            b = b & rnd_diff() & rnd_diff();
            d = d & rnd_diff() & rnd_diff();
            return;
        end
        b       = a ^ (rnd_diff() & rnd_diff());
        d       = a ^ (rnd_diff() & rnd_diff());
        eq_prev = 1'b0;
        x_prev  = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (k == 0 && i == 0)
                d[i] = a[i] ^ b[i];
            else if (i > 0 && eq_prev && i != k)
                d[i] = a[i] ^ b[i] ^ x_prev;
            x_prev  = a[i] ^ b[i] ^ d[i];
            eq_prev = (a[i] == d[i]) && (b[i] == d[i]);
        end
    endfunction

    task automatic send_word(logic [DIFF_W-1:0] a, logic [DIFF_W-1:0] b,
                             logic [DIFF_W-1:0] d);
        int unsigned gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, d, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(a, b, d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(PDATA_W-WORD_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic set_config(logic [WORD_W-1:0] ws, logic [WORD_W-1:0] rot);
        drain();
        apb_write(REG_WORD_SIZE, ws);
        apb_write(REG_ROTATION, rot);
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (rx_hold == 0 && rx_idle_en)
            rx_hold = pick_gap();
        if (rx_hold != 0)
        begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("** rx_differential_count_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned       ws;
        int unsigned       rot;
        int unsigned       settle;
        logic [DIFF_W-1:0] a;
        logic [DIFF_W-1:0] b;
        logic [DIFF_W-1:0] d;
        sb         = new();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold    = 0;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        m_tready   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, bits above word size ignored
        send_word(31'h0, 31'h0, 31'h0);
        send_word(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_word(31'h7FFF0000, 31'h7FFF0000, 31'h0);
        send_word(31'h0000FFFF, 31'h0, 31'h0);

        set_config(5'd31, 5'd0);
        send_word(31'h0, 31'h0, 31'h0);
        send_word(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_word(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h0);
        send_word(31'h1, 31'h0, 31'h0);

        set_config(5'd31, 5'd30);
        send_word(31'h0, 31'h0, 31'h0);
        send_word(31'h0, 31'h0, 31'h7FFFFFFF);
        send_word(31'h40000000, 31'h0, 31'h0);

        // one- and two-bit words
        set_config(5'd1, 5'd0);
        send_word(31'h0, 31'h0, 31'h0);
        send_word(31'h1, 31'h1, 31'h1);
        send_word(31'h7FFFFFFE, 31'h0, 31'h0);

        set_config(5'd2, 5'd1);
        send_word(31'h0, 31'h0, 31'h0);
        send_word(31'h3, 31'h0, 31'h0);
        send_word(31'h1, 31'h2, 31'h3);

        // rotation not below word size
        set_config(5'd0, 5'd0);
        send_word(31'h0, 31'h0, 31'h0);
        set_config(5'd31, 5'd31);
        send_word(31'h1, 31'h2, 31'h3);
        set_config(5'd8, 5'd9);
        send_word(31'h7FFFFFFF, 31'h0, 31'h55);

        for (int p = 0; p < 14; p++)
        begin
            case (p)
                0:       begin ws = 31; rot = 0;  end
                1:       begin ws = 31; rot = 30; end
                2:       begin ws = 31; rot = 15; end
                3:       begin ws = 2;  rot = 1;  end
                4:       begin ws = 16; rot = 1;  end
                5:       begin ws = 1;  rot = 0;  end
                6:       begin ws = 24; rot = 3;  end
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        ws  = $urandom_range(0, 31);
                        rot = $urandom_range(ws, 31);
                    end
                    else
                    begin
                        ws  = $urandom_range(2, 31);
                        rot = $urandom_range(0, ws - 1);
                    end
                end
            endcase
            set_config(WORD_W'(ws), WORD_W'(rot));
            tx_idle_en = (p % 3 != 0);
            rx_idle_en = (p % 4 != 0);
            for (int i = 0; i < 125; i++)
            begin
                if ((p == 5 || p == 9) && i == 60)
                    drain();
                make_triple(ws, rot, a, b, d);
                send_word(a, b, d);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        settle = 0;
        while (sb.outstanding() != 0 && settle < 20000)
        begin
            settle++;
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("** rx_differential_count_unit: PASSED **");
        else
            $display("** rx_differential_count_unit: FAILED **");
        $finish;
    end

endmodule

FILE: rx_differential_count_unit.f
sv/rxdc_pkg.sv
sv/rxdc_cfg.sv
sv/rxdc_front.sv
sv/rxdc_count.sv
sv/rxdc_combine.sv
sv/rx_differential_count_unit.sv
tb/tb_rx_differential_count_unit.sv
